FILE: hdl/mrfc_pkg.sv
// shared types and constants of the modbus rtu frame checker
package mrfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 9;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 8;

  localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 16'hA001;
  localparam logic [ByteW-1:0] ExcFlag = 8'h80;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK         = 3'd0,
    STATUS_TOO_SHORT  = 3'd1,
    STATUS_REQ_EXC    = 3'd2,
    STATUS_CRC_ERR    = 3'd3,
    STATUS_SLAVE_ERR  = 3'd4,
    STATUS_FUNC_ERR   = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHECK_MODE   = 8'd0,
    REG_MATCH_ENABLE = 8'd1,
    REG_EXP_SLAVE    = 8'd2,
    REG_EXP_FUNCTION = 8'd3
  } reg_idx_e;

  // one input beat as held in the input register
  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             last_byte;
  } in_item_t;

  // configuration seen by the check logic
  typedef struct packed {
    logic             check_mode;
    logic             match_enable;
    logic [ByteW-1:0] expected_slave;
    logic [ByteW-1:0] expected_function;
  } cfg_t;

endpackage

FILE: hdl/mrfc_if.sv
// channel interfaces: frame bytes in, verdicts out, register writes
interface mrfc_in_if import mrfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface mrfc_out_if import mrfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic               is_exception;
  logic [LenW-1:0]    frame_length;
  logic [CrcW-1:0]    computed_crc;

  modport source (output valid, status, is_exception, frame_length, computed_crc,
                  input ready);
  modport sink   (input valid, status, is_exception, frame_length, computed_crc,
                  output ready);
endinterface

interface mrfc_cfg_if import mrfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/mrfc_in_reg.sv
// input register stage for frame byte beats
module mrfc_in_reg import mrfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrfc_in_if.sink    in_i,
  input  logic       advance_i,
  output logic       valid_o,
  output in_item_t   item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.frame_byte <= in_i.frame_byte;
      item_q.last_byte  <= in_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hdl/mrfc_frame_check.sv
// per-frame state, crc update, verdict logic and result register
module mrfc_frame_check import mrfc_pkg::*; #(
  parameter int unsigned MaxFrameBytes = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  input  in_item_t   item_i,
  output logic       advance_o,
  mrfc_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MaxFrameBytes + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxFrameBytes);

  function automatic logic [CrcW-1:0] crc_feed(logic [CrcW-1:0] crc,
                                               logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // frame state
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] held0_q, held0_d, held1_q, held1_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0] slave_q, slave_d, func_q, func_d;

  // result register
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic             exc_q, exc_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [CrcW-1:0]  ocrc_q, ocrc_d;

  logic [CntW-1:0]  cnt_nx;
  logic [CrcW-1:0]  crc_nx;
  logic [ByteW-1:0] slave_nx, func_nx;
  logic [CrcW-1:0]  rx_crc;
  logic [CntW+LenW-1:0] cnt_ext;
  logic             emit;

  assign advance_o = valid_i && (!item_i.last_byte || !out_valid_q || out_o.ready);
  assign emit      = advance_o && item_i.last_byte;

  always_comb begin
    slave_nx   = (cnt_q == CntW'(0)) ? item_i.frame_byte : slave_q;
    func_nx    = (cnt_q == CntW'(1)) ? item_i.frame_byte : func_q;
    crc_nx     = (cnt_q >= CntW'(2)) ? crc_feed(crc_q, held0_q) : crc_q;
    cnt_nx     = (cnt_q == CntMax) ? cnt_q : cnt_q + CntW'(1);
    rx_crc     = {item_i.frame_byte, held1_q};
    cnt_ext    = (CntW+LenW)'(cnt_nx);
    exc_d      = (func_nx & ExcFlag) != '0;
    len_d      = cnt_ext[LenW-1:0];
    ocrc_d     = crc_nx;

    if (!cfg_i.check_mode) begin
      if (cnt_nx < CntW'(5))          status_d = STATUS_TOO_SHORT;
      else if (exc_d)                 status_d = STATUS_REQ_EXC;
      else if (crc_nx != rx_crc)      status_d = STATUS_CRC_ERR;
      else                            status_d = STATUS_OK;
    end else begin
      if (cnt_nx < (exc_d ? CntW'(5) : CntW'(6))) begin
        status_d = STATUS_TOO_SHORT;
      end else if (crc_nx != rx_crc) begin
        status_d = STATUS_CRC_ERR;
      end else if (cfg_i.match_enable && slave_nx != cfg_i.expected_slave) begin
        status_d = STATUS_SLAVE_ERR;
      end else if (cfg_i.match_enable &&
                   (func_nx & ~ExcFlag) != cfg_i.expected_function) begin
        status_d = STATUS_FUNC_ERR;
      end else begin
        status_d = STATUS_OK;
      end
    end

    // state advance; a verdict returns the frame state to its idle values
    crc_d   = crc_q;
    held0_d = held0_q;
    held1_d = held1_q;
    cnt_d   = cnt_q;
    slave_d = slave_q;
    func_d  = func_q;
    if (emit) begin
      crc_d   = CrcInit;
      held0_d = '0;
      held1_d = '0;
      cnt_d   = '0;
      slave_d = '0;
      func_d  = '0;
    end else if (advance_o) begin
      crc_d   = crc_nx;
      held0_d = held1_q;
      held1_d = item_i.frame_byte;
      cnt_d   = cnt_nx;
      slave_d = slave_nx;
      func_d  = func_nx;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      held0_q     <= '0;
      held1_q     <= '0;
      cnt_q       <= '0;
      slave_q     <= '0;
      func_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      held0_q     <= held0_d;
      held1_q     <= held1_d;
      cnt_q       <= cnt_d;
      slave_q     <= slave_d;
      func_q      <= func_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status_d;
      exc_q    <= exc_d;
      len_q    <= len_d;
      ocrc_q   <= ocrc_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.is_exception = exc_q;
  assign out_o.frame_length = len_q;
  assign out_o.computed_crc = ocrc_q;

endmodule

FILE: hdl/modbus_rtu_frame_checker.sv
// top level of the modbus rtu frame checker
//
//  channel    dir  handshake    payload
//  frame_in_i in   valid/ready  frame_byte[7:0], last_byte
//  verdict_o  out  valid/ready  status[2:0], is_exception, frame_length[8:0],
//                               computed_crc[15:0]
//  cfg_i      in   valid/ready  index[7:0], data[7:0]
//
// one byte beat is taken per cycle unless a held verdict stalls the input;
// a byte waits in the input register and is folded into the frame state
// (unrolled 8-bit crc step plus compare) as it leaves; the verdict is registered
// reset clears the frame state, the config registers and both valid flags
// a verdict still held when the next last byte reaches the input register
// stalls that byte there, and the input with it; other bytes keep flowing
// config writes are always taken and land in the next cycle
module modbus_rtu_frame_checker import mrfc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrfc_in_if.sink    frame_in_i,
  mrfc_out_if.source verdict_o,
  mrfc_cfg_if.sink   cfg_i
);

  cfg_t     cfg_q;
  logic     s1_valid;
  in_item_t s1_item;
  logic     advance;

  // register writes; indexes past the list are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CHECK_MODE:   cfg_q.check_mode        <= cfg_i.data[0];
        REG_MATCH_ENABLE: cfg_q.match_enable      <= cfg_i.data[0];
        REG_EXP_SLAVE:    cfg_q.expected_slave    <= cfg_i.data;
        REG_EXP_FUNCTION: cfg_q.expected_function <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register
  mrfc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (frame_in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  // frame state, crc, verdict and result register
  mrfc_frame_check #(
    .MaxFrameBytes (MAX_FRAME_BYTES)
  ) u_frame_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (s1_valid),
    .item_i    (s1_item),
    .advance_o (advance),
    .out_o     (verdict_o)
  );

endmodule

FILE: tb/sv/mrfc_verdict_checker.sv
`timescale 1ns / 1ps
// verdict checker: mirrors the frame checker state and compares every verdict beat
module mrfc_verdict_checker import mrfc_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrfc_in_if          frame_mon,
  mrfc_out_if         verdict_mon,
  mrfc_cfg_if         cfg_mon,
  output int unsigned mismatch_count_o,
  output int unsigned verdicts_due_o,
  output int unsigned verdicts_checked_o
);

  localparam int unsigned MinReqLen  = 5;
  localparam int unsigned MinExcLen  = 5;
  localparam int unsigned MinRespLen = 6;

  typedef struct packed {
    status_e          status;
    logic             is_exception;
    logic [LenW-1:0]  frame_length;
    logic [CrcW-1:0]  computed_crc;
  } verdict_t;

  cfg_t             regs;
  logic [CrcW-1:0]  crc_acc;
  logic [ByteW-1:0] tail_byte [2];
  logic [LenW-1:0]  byte_cnt;
  logic [ByteW-1:0] slave_b;
  logic [ByteW-1:0] func_b;
  verdict_t         verdict_q [$];
  int unsigned      mismatch_cnt;
  int unsigned      checked_cnt;

  function automatic logic [CrcW-1:0] crc16_fold(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic void restart_frame();
    crc_acc      = CrcInit;
    tail_byte[0] = '0;
    tail_byte[1] = '0;
    byte_cnt     = '0;
    slave_b      = '0;
    func_b       = '0;
  endfunction

  // the newest two bytes wait in a delay line, so a byte enters the crc
  // only once two newer ones exist; returns 1 when a verdict is due
  function automatic bit absorb_byte(input logic [ByteW-1:0] b, input logic last,
                                     output verdict_t v);
    logic            exc;
    logic [CrcW-1:0] sent_crc;
    v = '0;
    if (byte_cnt == 0) slave_b = b;
    else if (byte_cnt == 1) func_b = b;
    if (byte_cnt >= 2) crc_acc = crc16_fold(crc_acc, tail_byte[0]);
    tail_byte[0] = tail_byte[1];
    tail_byte[1] = b;
    if (byte_cnt < MAX_FRAME_BYTES) byte_cnt++;
    if (!last) return 1'b0;

    exc      = (func_b & ExcFlag) != 0;
    sent_crc = {tail_byte[1], tail_byte[0]};
    if (!regs.check_mode) begin
      if (byte_cnt < MinReqLen) v.status = STATUS_TOO_SHORT;
      else if (exc) v.status = STATUS_REQ_EXC;
      else if (crc_acc != sent_crc) v.status = STATUS_CRC_ERR;
      else v.status = STATUS_OK;
    end else begin
      if (byte_cnt < (exc ? MinExcLen : MinRespLen)) v.status = STATUS_TOO_SHORT;
      else if (crc_acc != sent_crc) v.status = STATUS_CRC_ERR;
      else if (regs.match_enable && slave_b != regs.expected_slave) v.status = STATUS_SLAVE_ERR;
      else if (regs.match_enable && (func_b & ~ExcFlag) != regs.expected_function)
        v.status = STATUS_FUNC_ERR;
      else v.status = STATUS_OK;
    end
    v.is_exception = exc;
    v.frame_length = byte_cnt;
    v.computed_crc = crc_acc;
    restart_frame();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("t=%0t mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t fresh;
    verdict_t oldest;
    if (!rst_ni) begin
      regs = '0;
      restart_frame();
      verdict_q.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
    end else begin
      if (verdict_mon.valid && verdict_mon.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict beat with no frame waiting for one");
        end else begin
          oldest = verdict_q.pop_front();
          checked_cnt++;
          if (verdict_mon.status !== oldest.status)
            report_mismatch($sformatf("verdict %0d status %0d, expected %s", checked_cnt,
                                      verdict_mon.status, oldest.status.name()));
          if (verdict_mon.is_exception !== oldest.is_exception)
            report_mismatch($sformatf("verdict %0d is_exception %0b, expected %0b",
                                      checked_cnt, verdict_mon.is_exception,
                                      oldest.is_exception));
          if (verdict_mon.frame_length !== oldest.frame_length)
            report_mismatch($sformatf("verdict %0d frame_length %0d, expected %0d",
                                      checked_cnt, verdict_mon.frame_length,
                                      oldest.frame_length));
          if (verdict_mon.computed_crc !== oldest.computed_crc)
            report_mismatch($sformatf("verdict %0d computed_crc %h, expected %h",
                                      checked_cnt, verdict_mon.computed_crc,
                                      oldest.computed_crc));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_CHECK_MODE:   regs.check_mode        = cfg_mon.data[0];
          REG_MATCH_ENABLE: regs.match_enable      = cfg_mon.data[0];
          REG_EXP_SLAVE:    regs.expected_slave    = cfg_mon.data;
          REG_EXP_FUNCTION: regs.expected_function = cfg_mon.data;
          default: ;
        endcase
      end
      if (frame_mon.valid && frame_mon.ready) begin
        if (absorb_byte(frame_mon.frame_byte, frame_mon.last_byte, fresh))
          verdict_q.push_back(fresh);
      end
    end
    mismatch_count_o   <= mismatch_cnt;
    verdicts_due_o     <= verdict_q.size();
    verdicts_checked_o <= checked_cnt;
  end

endmodule

FILE: tb/sv/modbus_rtu_frame_checker_tb.sv
`timescale 1ns / 1ps
// testbench top: feeds rtu frames and register writes to the frame checker and judges the run
module modbus_rtu_frame_checker_tb;
  import mrfc_pkg::*;

  localparam int unsigned MaxFrameBytes  = 256;
  localparam int unsigned ItemTarget     = 1850;
  localparam int unsigned PhaseItems     = 150;
  localparam int unsigned HoldFrames     = 40;
  localparam int unsigned LongHoldCycles = 200;
  // a verdict passes the input register, then the result register; margin on top
  localparam int unsigned SettleCycles   = 4;
  localparam logic [CfgIdxW-1:0] FirstUnusedRegIdx = CfgIdxW'(REG_EXP_FUNCTION + 1);

  logic clk_i = 1'b0;
  logic rst_ni;

  mrfc_in_if  frame_in_if ();
  mrfc_out_if verdict_if ();
  mrfc_cfg_if cfg_if ();

  int unsigned mismatches;
  int unsigned verdicts_due;
  int unsigned verdicts_checked;

  // stimulus state
  logic [ByteW-1:0] frame_q [$];
  logic [ByteW-1:0] cur_slave;
  logic [ByteW-1:0] cur_func;
  int unsigned      burst_left;
  int unsigned      items_sent;
  int unsigned      frames_sent;
  int unsigned      settings_cnt;
  int unsigned      holds_asked;
  int unsigned      holds_served;
  bit               steady_sender;
  bit               long_due;

  always #2 clk_i = ~clk_i;

  modbus_rtu_frame_checker #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .frame_in_i (frame_in_if),
    .verdict_o  (verdict_if),
    .cfg_i      (cfg_if)
  );

  mrfc_verdict_checker #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) u_chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .frame_mon          (frame_in_if),
    .verdict_mon        (verdict_if),
    .cfg_mon            (cfg_if),
    .mismatch_count_o   (mismatches),
    .verdicts_due_o     (verdicts_due),
    .verdicts_checked_o (verdicts_checked)
  );

  // used only to build frames with a good checksum
  function automatic logic [CrcW-1:0] crc16_update(input logic [CrcW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // rtu order: crc low byte first
  function automatic void append_crc();
    logic [CrcW-1:0] c;
    c = CrcInit;
    foreach (frame_q[i]) c = crc16_update(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endfunction

  // register values biased toward the corners of the byte
  function automatic logic [ByteW-1:0] pick_reg_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return ExcFlag;
      default: return 8'($urandom);
    endcase
  endfunction

  // one byte beat; the sender runs in bursts with random gaps unless the
  // phase asks for a steady stream
  task automatic send_beat(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        frame_in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    frame_in_if.valid      <= 1'b1;
    frame_in_if.frame_byte <= b;
    frame_in_if.last_byte  <= last;
    do @(posedge clk_i); while (!frame_in_if.ready);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // stop offering bytes and wait until every verdict has been taken, then
  // give the pipeline time to empty
  task automatic wait_until_settled();
    frame_in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // valid stays high across a batch of writes; the caller lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] dat);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= dat;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // registers change only with the block idle and between frames
  task automatic apply_settings(input logic mode, input logic match,
                                input logic [ByteW-1:0] slave, input logic [ByteW-1:0] func);
    wait_until_settled();
    write_reg(REG_CHECK_MODE, CfgDatW'(mode));
    write_reg(REG_MATCH_ENABLE, CfgDatW'(match));
    write_reg(REG_EXP_SLAVE, slave);
    write_reg(REG_EXP_FUNCTION, func);
    // an index past the register list must leave everything alone
    if ($urandom_range(0, 1) == 0)
      write_reg(CfgIdxW'($urandom_range(FirstUnusedRegIdx, 255)), 8'($urandom));
    cfg_if.valid <= 1'b0;
    cur_slave = slave;
    cur_func  = func;
    settings_cnt++;
  endtask

  // mostly well-formed frames with random payload, aimed at the configured
  // slave and function; some get a flipped bit, some are plain noise
  task automatic build_frame();
    int unsigned      kind;
    int unsigned      n;
    int unsigned      pos;
    logic [ByteW-1:0] slave_b;
    logic [ByteW-1:0] func_b;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) frame_q.push_back(8'($urandom));
      return;
    end
    slave_b = ($urandom_range(0, 2) != 0) ? cur_slave : 8'($urandom);
    case ($urandom_range(0, 3))
      0: func_b = 8'($urandom);
      1: func_b = cur_func | ExcFlag;
      default: func_b = cur_func;
    endcase
    frame_q.push_back(slave_b);
    frame_q.push_back(func_b);
    // exception replies mostly carry one code byte; once in a while a frame runs
    // past the byte counter's ceiling
    if ((func_b & ExcFlag) != 0) begin
      n = ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(0, 4);
    end else if (long_due) begin
      n = $urandom_range(MaxFrameBytes + 1, MaxFrameBytes + 60);
      long_due = 1'b0;
    end else if ($urandom_range(0, 99) == 0) begin
      n = $urandom_range(MaxFrameBytes - 6, MaxFrameBytes + 60);
    end else begin
      n = $urandom_range(0, 10);
    end
    repeat (n) frame_q.push_back(8'($urandom));
    append_crc();
    if (kind < 27) begin
      pos = $urandom_range(0, frame_q.size() - 1);
      frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
  endtask

  // verdict side: ready follows a random 16-bit pattern, picked anew from one of
  // four mixes; bit 0 is always set so ready rises in every pass through it.
  // a hold request from the stimulus pulls ready low for a long stretch
  initial begin : verdict_sink
    logic [15:0] stall_pat;
    int unsigned cyc;
    verdict_if.ready <= 1'b0;
    stall_pat = '1;
    cyc       = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        verdict_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        holds_served++;
      end else begin
        if (cyc % 64 == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom) | 16'($urandom);
            default: stall_pat = 16'($urandom) & 16'($urandom);
          endcase
          stall_pat[0] = 1'b1;
        end
        verdict_if.ready <= stall_pat[cyc % 16];
        cyc++;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_start;
    rst_ni                 = 1'b0;
    frame_in_if.valid      <= 1'b0;
    frame_in_if.frame_byte <= '0;
    frame_in_if.last_byte  <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= '0;
    cfg_if.data            <= '0;
    burst_left   = 0;
    items_sent   = 0;
    frames_sent  = 0;
    settings_cnt = 0;
    holds_asked  = 0;
    holds_served = 0;
    steady_sender = 1'b0;
    long_due     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, request checks
    apply_settings(1'b0, 1'b1, 8'hFF, 8'h00);
    // single byte: function reads as zero, too short
    frame_q = '{8'hFF};
    send_frame();
    // two bytes: nothing reaches the crc, exception flag seen
    frame_q = '{8'h00, ExcFlag};
    send_frame();
    // exception flag in a request with a good crc
    frame_q = '{8'h01, 8'h83, 8'h02};
    append_crc();
    send_frame();

    // directed, response checks against slave 0x11 function 0x03
    apply_settings(1'b1, 1'b1, 8'h11, 8'h03);
    // minimal exception reply, everything matches
    frame_q = '{8'h11, 8'h83, 8'h02};
    append_crc();
    send_frame();
    // wrong slave
    frame_q = '{8'h12, 8'h83, 8'h02};
    append_crc();
    send_frame();
    // wrong function once the flag is stripped
    frame_q = '{8'h11, 8'h84, 8'h02};
    append_crc();
    send_frame();

    // random phases, the first few pinned to corner settings
    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase)
        0: apply_settings(1'b1, 1'b1, 8'h00, 8'h00);
        // expected function with the flag set can never match
        1: apply_settings(1'b1, 1'b1, 8'hFF, 8'hFF);
        2: apply_settings(1'b0, 1'b0, 8'hFF, 8'h7F);
        3: apply_settings(1'b1, 1'b0, 8'h00, 8'hFF);
        default: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                pick_reg_byte(), pick_reg_byte());
      endcase
      steady_sender = (phase % 4 == 2);
      if (phase == 3) long_due = 1'b1;
      // back-pressure: the sink holds off while one-byte frames keep coming,
      // so a verdict waits in the result register and the input stalls
      if (phase == 1) begin
        holds_asked++;
        repeat (HoldFrames) begin
          frame_q.delete();
          frame_q.push_back(8'($urandom));
          send_frame();
        end
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        build_frame();
        send_frame();
        if ($urandom_range(0, 29) == 0) wait_until_settled();
      end
      phase++;
    end

    wait_until_settled();
    $display("sent %0d bytes in %0d frames across %0d register settings",
             items_sent, frames_sent, settings_cnt);
    $display("compared %0d verdicts, %0d field mismatches", verdicts_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // generous ceiling of 2 ms, far above the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("run timed out with %0d verdicts outstanding", verdicts_due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
hdl/mrfc_pkg.sv
hdl/mrfc_if.sv
hdl/mrfc_in_reg.sv
hdl/mrfc_frame_check.sv
hdl/modbus_rtu_frame_checker.sv
tb/sv/mrfc_verdict_checker.sv
tb/sv/modbus_rtu_frame_checker_tb.sv
